// ----- rtl/mfrd_pkg.sv -----
// ----------------------------------------------------------------------------
// mfrd_pkg
// Shared constants, payload types and controller/datapath links for the
// monochrome page framebuffer rectangle draw unit.
// ----------------------------------------------------------------------------
package mfrd_pkg;

   // screen geometry
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W        = $clog2(STORE_SIZE);
   localparam int COORD_MAX     = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int COORD_W       = $clog2(COORD_MAX + 1);
   localparam int PAGE_W        = COORD_W - 3;

   // byte constants
   localparam logic [7:0] FILL_ONES   = 8'hFF;
   localparam logic [2:0] BIT_IDX_MAX = 3'd7;

   // function codes
   localparam logic [1:0] FUNC_RECT = 2'd0;
   localparam logic [1:0] FUNC_FILL = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   // rectangle edges in drawing order
   localparam logic [1:0] EDGE_TOP    = 2'd0;
   localparam logic [1:0] EDGE_BOTTOM = 2'd1;
   localparam logic [1:0] EDGE_LEFT   = 2'd2;
   localparam logic [1:0] EDGE_RIGHT  = 2'd3;

   // input beat
   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         rect_width;
      logic [7:0]         rect_height;
      logic               pixel_color;
      logic [9:0]         byte_index;
      logic               clear_after_read;
   } req_type;

   // result beat
   typedef struct packed {
      logic [7:0] read_byte;
      logic       read_valid;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       edge_load;
      logic       rmw_issue;
      logic       sweep_write;
      logic       sweep_fill;
      logic       byte_read;
      logic       byte_capture;
      logic       push;
      logic [1:0] edge_sel;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic edge_ok;
      logic cursor_last;
      logic sweep_last;
      logic out_busy;
   } dp_status_type;

endpackage

// ----- rtl/mfrd_ram.sv -----
// ----------------------------------------------------------------------------
// mfrd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mfrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mfrd_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfrd_ctrl
// Sequencer for the draw unit: clearing pass after reset, rectangle edges,
// screen fill, byte readout and result hand-off.
// ----------------------------------------------------------------------------
module mfrd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_func,
   input  mfrd_pkg::dp_status_type status,
   output mfrd_pkg::dp_cmd_type    cmd
);
   import mfrd_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EDGE  = 3'd2;
   localparam logic [2:0] S_RUN   = 3'd3;
   localparam logic [2:0] S_FILL  = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_CAPT  = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [1:0] edge_ff, edge_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      edge_in  = edge_ff;
      cmd      = '0;
      cmd.edge_sel = edge_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               edge_in  = EDGE_TOP;
               unique case (req_func)
                  FUNC_RECT: state_in = S_EDGE;
                  FUNC_FILL: state_in = S_FILL;
                  FUNC_READ: state_in = S_READ;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_EDGE: begin
            // also serves as the gap that lets the last pixel write land
            cmd.edge_load = 1'b1;
            if (status.edge_ok) begin
               state_in = S_RUN;
            end else if (edge_ff == EDGE_RIGHT) begin
               state_in = S_DONE;
            end else begin
               edge_in = edge_ff + 2'd1;
            end
         end
         S_RUN: begin
            cmd.rmw_issue = 1'b1;
            if (status.cursor_last) begin
               if (edge_ff == EDGE_RIGHT) begin
                  state_in = S_DONE;
               end else begin
                  edge_in  = edge_ff + 2'd1;
                  state_in = S_EDGE;
               end
            end
         end
         S_FILL: begin
            cmd.sweep_write = 1'b1;
            cmd.sweep_fill  = 1'b1;
            if (status.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            cmd.byte_read = 1'b1;
            state_in      = S_CAPT;
         end
         S_CAPT: begin
            cmd.byte_capture = 1'b1;
            state_in         = S_DONE;
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         edge_ff  <= EDGE_TOP;
      end else begin
         state_ff <= state_in;
         edge_ff  <= edge_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ----- rtl/mfrd_dpath.sv -----
// ----------------------------------------------------------------------------
// mfrd_dpath
// Datapath: item register, edge clipping, pixel cursor, read-modify-write
// pipeline into the frame store, sweep counter and result register.
// ----------------------------------------------------------------------------
module mfrd_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  mfrd_pkg::req_type       req_data,
   input  mfrd_pkg::dp_cmd_type    cmd,
   output mfrd_pkg::dp_status_type status,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output mfrd_pkg::rsp_type       rsp_data
);
   import mfrd_pkg::*;

   req_type             item_ff, item_in;
   logic [COORD_W-1:0]  cursor_ff, cursor_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [7:0]          pend_mask_ff, pend_mask_in;
   logic [7:0]          rb_ff, rb_in;
   logic                rv_ff, rv_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // edge coordinates, 16-bit wrap as in the drawing rules
   logic signed [15:0]  x_right, y_bottom, x_end;
   logic signed [16:0]  y_ext, y_end, row_start, row_stop;
   logic signed [15:0]  h_row, v_col;
   logic                h_ok, v_ok, is_vert;
   logic [COORD_W-1:0]  h_first, h_stop, v_rs, v_re, v_first, v_last;
   logic [2:0]          v_lo, v_hi;
   logic [7:0]          h_mask, v_mask;
   logic                edge_ok;
   logic [COORD_W-1:0]  edge_first, edge_last, pix_col;
   logic [PAGE_W-1:0]   pix_page;
   logic [7:0]          pix_mask;
   logic [ADDR_W-1:0]   pix_addr, byte_addr;
   logic                idx_ok;

   // ram ports
   logic                ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [7:0]          ram_wr_data, ram_rd_data;

   assign x_right  = item_ff.pos_x + $signed({8'd0, item_ff.rect_width}) - 16'sd1;
   assign y_bottom = item_ff.pos_y + $signed({8'd0, item_ff.rect_height}) - 16'sd1;
   assign x_end    = item_ff.pos_x + $signed({8'd0, item_ff.rect_width});
   assign y_ext    = {item_ff.pos_y[15], item_ff.pos_y};
   assign y_end    = y_ext + $signed({9'd0, item_ff.rect_height});

   // horizontal edge clipping
   always_comb begin
      h_row   = (cmd.edge_sel == EDGE_TOP) ? item_ff.pos_y : y_bottom;
      h_first = item_ff.pos_x[15] ? '0 : COORD_W'(item_ff.pos_x);
      h_stop  = (x_end > 16'(SCREEN_WIDTH)) ? COORD_W'(SCREEN_WIDTH) : COORD_W'(x_end);
      h_ok    = !h_row[15] && (h_row < 16'(SCREEN_HEIGHT)) && !x_end[15] &&
                (x_end != 16'sd0) && (item_ff.pos_x < 16'(SCREEN_WIDTH)) &&
                (h_first < h_stop);
      h_mask  = 8'd1 << h_row[2:0];
   end

   // vertical edge clipping, one byte per page
   always_comb begin
      v_col     = (cmd.edge_sel == EDGE_LEFT) ? item_ff.pos_x : x_right;
      row_start = y_ext[16] ? '0 : y_ext;
      row_stop  = (y_end > 17'(SCREEN_HEIGHT)) ? 17'(SCREEN_HEIGHT) : y_end;
      v_ok      = !v_col[15] && (v_col < 16'(SCREEN_WIDTH)) && (row_stop > row_start);
      v_rs      = COORD_W'(row_start);
      v_re      = COORD_W'(row_stop - 17'sd1);
      v_first   = v_rs >> 3;
      v_last    = v_re >> 3;
      v_lo      = (cursor_ff == v_first) ? v_rs[2:0] : 3'd0;
      v_hi      = (cursor_ff == v_last) ? v_re[2:0] : BIT_IDX_MAX;
      v_mask    = (FILL_ONES << v_lo) & (FILL_ONES >> (BIT_IDX_MAX - v_hi));
   end

   // edge selection and pixel address
   always_comb begin
      is_vert = (cmd.edge_sel == EDGE_LEFT) || (cmd.edge_sel == EDGE_RIGHT);
      if (is_vert) begin
         edge_ok    = v_ok;
         edge_first = v_first;
         edge_last  = v_last;
         pix_page   = PAGE_W'(cursor_ff);
         pix_col    = COORD_W'(v_col);
         pix_mask   = v_mask;
      end else begin
         edge_ok    = h_ok;
         edge_first = h_first;
         edge_last  = h_stop - COORD_W'(1);
         pix_page   = h_row[COORD_W-1:3];
         pix_col    = cursor_ff;
         pix_mask   = h_mask;
      end
      pix_addr = ADDR_W'(ADDR_W'(pix_page) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(pix_col);
   end

   assign idx_ok    = (32'(item_ff.byte_index) < STORE_SIZE);
   assign byte_addr = ADDR_W'(item_ff.byte_index);

   // ram read side
   assign ram_rd_en   = cmd.rmw_issue || (cmd.byte_read && idx_ok);
   assign ram_rd_addr = cmd.rmw_issue ? pix_addr : byte_addr;

   // ram write side: pixel write-back, sweep, clear after read
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = sweep_ff;
      ram_wr_data = '0;
      if (pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pend_addr_ff;
         ram_wr_data = item_ff.pixel_color ? (ram_rd_data | pend_mask_ff)
                                           : (ram_rd_data & ~pend_mask_ff);
      end else if (cmd.sweep_write) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sweep_ff;
         ram_wr_data = (cmd.sweep_fill && item_ff.pixel_color) ? FILL_ONES : 8'd0;
      end else if (cmd.byte_capture && idx_ok && item_ff.clear_after_read) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = byte_addr;
         ram_wr_data = 8'd0;
      end
   end

   mfrd_ram #(
      .WIDTH (8),
      .DEPTH (STORE_SIZE)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next values
   always_comb begin
      item_in      = cmd.load ? req_data : item_ff;
      cursor_in    = cursor_ff;
      if (cmd.edge_load) begin
         cursor_in = edge_first;
      end else if (cmd.rmw_issue) begin
         cursor_in = cursor_ff + COORD_W'(1);
      end
      sweep_in     = sweep_ff;
      if (cmd.sweep_write) begin
         sweep_in = status.sweep_last ? '0 : sweep_ff + ADDR_W'(1);
      end
      pend_in      = cmd.rmw_issue;
      pend_addr_in = pix_addr;
      pend_mask_in = pix_mask;
      rb_in        = rb_ff;
      rv_in        = rv_ff;
      if (cmd.load) begin
         rb_in = 8'd0;
         rv_in = 1'b0;
      end else if (cmd.byte_capture && idx_ok) begin
         rb_in = ram_rd_data;
         rv_in = 1'b1;
      end
      rsp_valid_in = cmd.push || (rsp_valid_ff && rsp_stall);
      rsp_in       = rsp_ff;
      if (cmd.push) begin
         rsp_in.read_byte  = rb_ff;
         rsp_in.read_valid = rv_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      cursor_ff    <= cursor_in;
      pend_addr_ff <= pend_addr_in;
      pend_mask_ff <= pend_mask_in;
      rb_ff        <= rb_in;
      rv_ff        <= rv_in;
      rsp_ff       <= rsp_in;
   end

   // status back to the controller
   always_comb begin
      status.edge_ok     = edge_ok;
      status.cursor_last = (cursor_ff == edge_last);
      status.sweep_last  = (sweep_ff == ADDR_W'(STORE_SIZE - 1));
      status.out_busy    = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/mono_framebuffer_rect_draw_unit.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_rect_draw_unit
// 1-bit-per-pixel page framebuffer with clipped rectangle outline drawing,
// whole-screen fill and byte readout with optional clear.
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat per command (outline, fill, read), taken when
//   req_valid is high and req_stall is low. rsp channel: exactly one beat per
//   command, held in an output register until rsp_stall is low.
//   steps per command, from accept to result loaded:
//     outline: each edge in turn (top, bottom, left, right) is clipped, then
//              updated one clipped horizontal pixel or touched vertical page at a time
//     fill:    every byte of the store written, one byte written a cycle
//     read:    one byte read, captured and optionally cleared; other codes: no work
//   pixels are updated by read-modify-write through the single write port of
//   the frame store, pipelined one pixel per cycle.
//   one command is worked at a time; the next is taken once the result sits
//   in the output register, even if the receiver is still stalling.
//   reset: a clearing pass writes zero to every byte, with req_stall held
//   high. a stalled result holds until taken, and a new result waits
//   behind it.
// ----------------------------------------------------------------------------
module mono_framebuffer_rect_draw_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mfrd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mfrd_pkg::rsp_type rsp_data
);
   import mfrd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   mfrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_data.func),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath with frame store
   mfrd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
